// ===== sv/cabn_pkg.sv =====
// ----------------------------------------------------------------------------
// cabn_pkg: shared types and constants for class-aware box suppression
// Holds field widths, the stored box layout and the IoU unit response type.
// ----------------------------------------------------------------------------
package cabn_pkg;

  localparam int unsigned COORD_W       = 16;
  localparam int unsigned SCORE_W       = 16;
  localparam int unsigned CLASS_W       = 7;
  localparam int unsigned MAX_BOXES_DEF = 64;
  localparam int unsigned ENTRY_W       = 4 * COORD_W + SCORE_W + CLASS_W;
  localparam int unsigned DATA_W        = ((ENTRY_W + 7) / 8) * 8;
  localparam logic [SCORE_W-1:0] THR_RESET = 16'd29491;

  // Corner set of one box, x1 in the lowest bits.
  typedef struct packed {
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
  } box_t;

  // One stored entry, laid out as the stream data word.
  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [SCORE_W-1:0] score;
    box_t               box;
  } entry_t;

  // Result of one overlap test.
  typedef struct packed {
    logic done;
    logic hit;
  } iou_resp_t;

endpackage

// ===== sv/class_aware_box_nms_unit.sv =====
// ----------------------------------------------------------------------------
// class_aware_box_nms_unit: class-aware non-maximum suppression
// Buffers a set of boxes, then streams the kept boxes in score order.
// ----------------------------------------------------------------------------
// Usage:
//   Boxes enter on the s_axis channel, one item per cycle, while the block
//   is loading. The item with s_axis_tlast high closes the set; boxes beyond
//   MAX_BOXES are dropped and every result of that set carries the overflow
//   flag in m_axis_tuser. After the closing item s_axis_tready stays low
//   until the last kept box has been taken on m_axis.
//   Processing repeats a max-score scan over the stored boxes (one memory
//   read port) and a suppression scan in which each live box of the same
//   class goes through the overlap test on the shared IoU multiplier.
//   Kept boxes leave in descending score, equal scores in arrival order,
//   with m_axis_tlast on the final one. A stalled receiver simply holds the
//   sequencer in its output state; nothing is lost.
//   Reset empties the set and loads the threshold default of 29491.
//   The user sets the threshold via cfg_we_i only while idle; not enforced.
// ----------------------------------------------------------------------------
module class_aware_box_nms_unit #(
  parameter int unsigned MAX_BOXES = cabn_pkg::MAX_BOXES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cabn_pkg::SCORE_W-1:0] cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // left, top, right, bottom, score, class, zero pad
  input  logic [cabn_pkg::DATA_W-1:0]  s_axis_tdata,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // left, top, right, bottom, score, class, zero pad
  output logic [cabn_pkg::DATA_W-1:0]  m_axis_tdata,
  output logic                         m_axis_tlast,
  // overflow
  output logic [0:0]                   m_axis_tuser
);

  localparam int unsigned IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);

  typedef enum logic [2:0] {
    ST_LOAD, ST_FIND_RD, ST_FIND_EV, ST_TAKE, ST_SUP_RD, ST_SUP_EV, ST_SUP_WAIT, ST_EMIT
  } nms_state_e;

  nms_state_e                   state_q;
  cabn_pkg::entry_t             mem [MAX_BOXES];
  cabn_pkg::entry_t             rdata_q, cand_q, cur_q;
  logic [CNT_W-1:0]             count_q, idx_q;
  logic [MAX_BOXES-1:0]         retired_q;
  logic                         overflow_q, found_q, pend_q, last_q, iou_start_q;
  logic [IDX_W-1:0]             best_idx_q;
  logic [cabn_pkg::SCORE_W-1:0] best_score_q, thr_q;
  cabn_pkg::iou_resp_t          iou_resp;
  logic                         in_acc, has_room, at_end;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign has_room = count_q < CNT_W'(MAX_BOXES);
  assign at_end   = idx_q == count_q;

  // Box store: written while loading, read one entry per cycle.
  always_ff @(posedge clk_i) begin
    if (in_acc && has_room) begin
      mem[count_q[IDX_W-1:0]] <= s_axis_tdata[cabn_pkg::ENTRY_W-1:0];
    end
    rdata_q <= mem[idx_q[IDX_W-1:0]];
  end

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= cabn_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Shared overlap test.
  cabn_iou_unit u_iou (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (iou_start_q),
    .box_a_i (cur_q.box),
    .box_b_i (rdata_q.box),
    .thr_i   (thr_q),
    .resp_o  (iou_resp)
  );

  // Sequencer: load, find the best live box, suppress, emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      count_q      <= '0;
      idx_q        <= '0;
      retired_q    <= '0;
      overflow_q   <= 1'b0;
      found_q      <= 1'b0;
      pend_q       <= 1'b0;
      last_q       <= 1'b0;
      iou_start_q  <= 1'b0;
      best_idx_q   <= '0;
      best_score_q <= '0;
      cand_q       <= '0;
      cur_q        <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (has_room) begin
              count_q <= count_q + CNT_W'(1);
            end else begin
              overflow_q <= 1'b1;
            end
            if (s_axis_tlast) begin
              idx_q   <= '0;
              found_q <= 1'b0;
              pend_q  <= 1'b0;
              state_q <= ST_FIND_RD;
            end
          end
        end
        ST_FIND_RD: begin
          if (at_end) begin
            if (pend_q) begin
              last_q  <= !found_q;
              state_q <= ST_EMIT;
            end else if (found_q) begin
              state_q <= ST_TAKE;
            end else begin
              count_q    <= '0;
              overflow_q <= 1'b0;
              retired_q  <= '0;
              state_q    <= ST_LOAD;
            end
          end else if (retired_q[idx_q[IDX_W-1:0]]) begin
            idx_q <= idx_q + CNT_W'(1);
          end else begin
            state_q <= ST_FIND_EV;
          end
        end
        ST_FIND_EV: begin
          // Strictly greater keeps the earliest box among equal scores.
          if (!found_q || (rdata_q.score > best_score_q)) begin
            found_q      <= 1'b1;
            best_score_q <= rdata_q.score;
            best_idx_q   <= idx_q[IDX_W-1:0];
            cand_q       <= rdata_q;
          end
          idx_q   <= idx_q + CNT_W'(1);
          state_q <= ST_FIND_RD;
        end
        ST_TAKE: begin
          cur_q                 <= cand_q;
          retired_q[best_idx_q] <= 1'b1;
          pend_q                <= 1'b1;
          idx_q                 <= '0;
          state_q               <= ST_SUP_RD;
        end
        ST_SUP_RD: begin
          if (at_end) begin
            idx_q   <= '0;
            found_q <= 1'b0;
            state_q <= ST_FIND_RD;
          end else if (retired_q[idx_q[IDX_W-1:0]]) begin
            idx_q <= idx_q + CNT_W'(1);
          end else begin
            state_q <= ST_SUP_EV;
          end
        end
        ST_SUP_EV: begin
          if (rdata_q.cls == cur_q.cls) begin
            iou_start_q <= 1'b1;
            state_q     <= ST_SUP_WAIT;
          end else begin
            idx_q   <= idx_q + CNT_W'(1);
            state_q <= ST_SUP_RD;
          end
        end
        ST_SUP_WAIT: begin
          iou_start_q <= 1'b0;
          if (iou_resp.done) begin
            if (iou_resp.hit) begin
              retired_q[idx_q[IDX_W-1:0]] <= 1'b1;
            end
            idx_q   <= idx_q + CNT_W'(1);
            state_q <= ST_SUP_RD;
          end
        end
        ST_EMIT: begin
          if (m_axis_tready) begin
            pend_q <= 1'b0;
            if (found_q) begin
              state_q <= ST_TAKE;
            end else begin
              count_q    <= '0;
              overflow_q <= 1'b0;
              retired_q  <= '0;
              state_q    <= ST_LOAD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  // Stream ports.
  assign s_axis_tready = state_q == ST_LOAD;
  assign m_axis_tvalid = state_q == ST_EMIT;
  assign m_axis_tdata  = {{(cabn_pkg::DATA_W - cabn_pkg::ENTRY_W){1'b0}}, cur_q};
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = overflow_q;

endmodule

// ===== sv/cabn_iou_unit.sv =====
// ----------------------------------------------------------------------------
// cabn_iou_unit: sequenced overlap test around one shared multiplier
// Decides inter * 65536 > threshold * union as a sequence of steps.
// ----------------------------------------------------------------------------
module cabn_iou_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  cabn_pkg::box_t               box_a_i,
  input  cabn_pkg::box_t               box_b_i,
  input  logic [cabn_pkg::SCORE_W-1:0] thr_i,
  output cabn_pkg::iou_resp_t          resp_o
);

  typedef enum logic [2:0] {
    I_IDLE, I_INTER, I_AREA_A, I_AREA_B, I_UNION, I_CHECK, I_PROD_LO, I_PROD_HI
  } iou_state_e;

  iou_state_e            state_q;
  cabn_pkg::box_t        a_q, b_q;
  logic [15:0]           thr_q;
  logic [31:0]           inter_q;
  logic signed [33:0]    area_a_q, area_b_q;
  logic [34:0]           union_q;
  logic [32:0]           plo_q;
  logic                  done_q, hit_q;

  logic [15:0]           lx, ly, hx, hy, w, h;
  logic [16:0]           dw, dh, dxa, dya, dxb, dyb;
  logic signed [18:0]    mul_a, mul_b;
  logic signed [37:0]    mul_p;
  logic [49:0]           lhs, rhs;

  // Overlap rectangle, clamped at zero.
  always_comb begin
    lx  = (a_q.left   > b_q.left)   ? a_q.left   : b_q.left;
    ly  = (a_q.top    > b_q.top)    ? a_q.top    : b_q.top;
    hx  = (a_q.right  < b_q.right)  ? a_q.right  : b_q.right;
    hy  = (a_q.bottom < b_q.bottom) ? a_q.bottom : b_q.bottom;
    dw  = {1'b0, hx} - {1'b0, lx};
    dh  = {1'b0, hy} - {1'b0, ly};
    w   = (!dw[16] && (dw != 17'd0)) ? dw[15:0] : 16'd0;
    h   = (!dh[16] && (dh != 17'd0)) ? dh[15:0] : 16'd0;
    dxa = {1'b0, a_q.right}  - {1'b0, a_q.left};
    dya = {1'b0, a_q.bottom} - {1'b0, a_q.top};
    dxb = {1'b0, b_q.right}  - {1'b0, b_q.left};
    dyb = {1'b0, b_q.bottom} - {1'b0, b_q.top};
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_q)
      I_INTER: begin
        mul_a = {3'b000, w};
        mul_b = {3'b000, h};
      end
      I_AREA_A: begin
        mul_a = {{2{dxa[16]}}, dxa};
        mul_b = {{2{dya[16]}}, dya};
      end
      I_AREA_B: begin
        mul_a = {{2{dxb[16]}}, dxb};
        mul_b = {{2{dyb[16]}}, dyb};
      end
      I_PROD_LO: begin
        mul_a = {3'b000, thr_q};
        mul_b = {2'b00, union_q[16:0]};
      end
      I_PROD_HI: begin
        mul_a = {3'b000, thr_q};
        mul_b = {2'b00, union_q[33:17]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Final compare uses the high product straight off the multiplier.
  assign lhs = {2'b00, inter_q, 16'h0000};
  assign rhs = {mul_p[32:0], 17'd0} + {17'd0, plo_q};

  // Sequencer: one multiplication at a time, each but the high product registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= I_IDLE;
      a_q      <= '0;
      b_q      <= '0;
      thr_q    <= '0;
      inter_q  <= '0;
      area_a_q <= '0;
      area_b_q <= '0;
      union_q  <= '0;
      plo_q    <= '0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        I_IDLE: begin
          if (start_i) begin
            a_q     <= box_a_i;
            b_q     <= box_b_i;
            thr_q   <= thr_i;
            state_q <= I_INTER;
          end
        end
        I_INTER: begin
          inter_q <= mul_p[31:0];
          state_q <= I_AREA_A;
        end
        I_AREA_A: begin
          area_a_q <= mul_p[33:0];
          state_q  <= I_AREA_B;
        end
        I_AREA_B: begin
          area_b_q <= mul_p[33:0];
          state_q  <= I_UNION;
        end
        I_UNION: begin
          union_q <= {area_a_q[33], area_a_q} + {area_b_q[33], area_b_q}
                     - {3'b000, inter_q};
          state_q <= I_CHECK;
        end
        I_CHECK: begin
          // A zero or negative union never suppresses.
          if (union_q[34] || (union_q == 35'd0)) begin
            hit_q   <= 1'b0;
            done_q  <= 1'b1;
            state_q <= I_IDLE;
          end else begin
            state_q <= I_PROD_LO;
          end
        end
        I_PROD_LO: begin
          plo_q   <= mul_p[32:0];
          state_q <= I_PROD_HI;
        end
        I_PROD_HI: begin
          hit_q   <= lhs > rhs;
          done_q  <= 1'b1;
          state_q <= I_IDLE;
        end
        default: state_q <= I_IDLE;
      endcase
    end
  end

  assign resp_o.done = done_q;
  assign resp_o.hit  = hit_q;

endmodule

// ===== sim/class_aware_box_nms_unit_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_aware_box_nms_unit_chk: result checker for the box suppression block
// Watches both streams, runs its own class-aware suppression on every closed
// set and compares each kept box with the oldest expected one.
// ----------------------------------------------------------------------------
module class_aware_box_nms_unit_chk #(
  parameter int unsigned MAX_BOXES = cabn_pkg::MAX_BOXES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cabn_pkg::SCORE_W-1:0] cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [cabn_pkg::DATA_W-1:0]  s_axis_tdata,
  input  logic                         s_axis_tlast,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [cabn_pkg::DATA_W-1:0]  m_axis_tdata,
  input  logic                         m_axis_tlast,
  input  logic [0:0]                   m_axis_tuser,
  output int                           fail_count,
  output int                           pending_count,
  output int                           kept_total,
  output int                           set_total
);

  typedef struct packed {
    cabn_pkg::entry_t ent;
    logic             last;
    logic             ovf;
  } kept_t;

  cabn_pkg::entry_t             set_boxes[$];
  logic                         set_ovf;
  logic [cabn_pkg::SCORE_W-1:0] iou_thr;
  kept_t                        kept_q[$];

  // True when box b overlaps kept box a beyond the threshold.
  function automatic bit overlap_exceeds(cabn_pkg::box_t a, cabn_pkg::box_t b,
                                         logic [cabn_pkg::SCORE_W-1:0] thr);
    longint lx, ly, hx, hy, w, h, inter, area_a, area_b, uni;
    lx = (a.left > b.left) ? a.left : b.left;
    ly = (a.top > b.top) ? a.top : b.top;
    hx = (a.right < b.right) ? a.right : b.right;
    hy = (a.bottom < b.bottom) ? a.bottom : b.bottom;
    w = (hx - lx > 0) ? hx - lx : 0;
    h = (hy - ly > 0) ? hy - ly : 0;
    inter = w * h;
    area_a = (longint'(a.right) - longint'(a.left)) * (longint'(a.bottom) - longint'(a.top));
    area_b = (longint'(b.right) - longint'(b.left)) * (longint'(b.bottom) - longint'(b.top));
    uni = area_a + area_b - inter;
    if (uni <= 0) return 0;
    return inter * 65536 > longint'(thr) * uni;
  endfunction

  // Sort the closed set by score (stable) and queue the surviving boxes.
  task automatic predict_kept_boxes();
    cabn_pkg::entry_t ordered[$];
    bit               dropped[$];
    int               j, first_new;
    cabn_pkg::entry_t cur;
    kept_t            item;
    ordered = {};
    foreach (set_boxes[i]) begin
      cur = set_boxes[i];
      j = ordered.size();
      while (j > 0 && ordered[j-1].score < cur.score) j--;
      ordered.insert(j, cur);
    end
    dropped = {};
    foreach (ordered[i]) dropped = {dropped, 1'b0};
    first_new = kept_q.size();
    foreach (ordered[i]) begin
      if (!dropped[i]) begin
        item = '{ent: ordered[i], last: 1'b0, ovf: set_ovf};
        kept_q = {kept_q, item};
        for (int k = i + 1; k < ordered.size(); k++)
          if (!dropped[k] && ordered[k].cls == ordered[i].cls &&
              overlap_exceeds(ordered[i].box, ordered[k].box, iou_thr))
            dropped[k] = 1;
      end
    end
    if (kept_q.size() > first_new) kept_q[kept_q.size()-1].last = 1'b1;
    set_boxes = {};
    set_ovf = 1'b0;
    set_total++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kept_t            got, want;
    cabn_pkg::entry_t box_in;
    if (!rst_ni) begin
      set_boxes = {};
      set_ovf = 1'b0;
      iou_thr = cabn_pkg::THR_RESET;
      kept_q = {};
      fail_count = 0;
      kept_total = 0;
      set_total = 0;
    end else begin
      if (cfg_we_i) iou_thr = cfg_wdata_i;
      // Input side: store the box or flag it as dropped.
      if (s_axis_tvalid && s_axis_tready) begin
        box_in = s_axis_tdata[cabn_pkg::ENTRY_W-1:0];
        if (set_boxes.size() < MAX_BOXES) set_boxes = {set_boxes, box_in};
        else set_ovf = 1'b1;
        if (s_axis_tlast) predict_kept_boxes();
      end
      // Output side: compare against the oldest expected kept box.
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{ent: cabn_pkg::entry_t'(m_axis_tdata[cabn_pkg::ENTRY_W-1:0]),
                last: m_axis_tlast, ovf: m_axis_tuser[0]};
        kept_total++;
        if (kept_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("ERROR: unexpected kept box %h", got);
        end else begin
          want = kept_q.pop_front();
          if (got != want ||
              m_axis_tdata[cabn_pkg::DATA_W-1:cabn_pkg::ENTRY_W] != '0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: kept box mismatch: expected %h got %h (pad %h)",
                       want, got, m_axis_tdata[cabn_pkg::DATA_W-1:cabn_pkg::ENTRY_W]);
          end
        end
      end
    end
    pending_count = kept_q.size();
  end
endmodule

// ===== sim/class_aware_box_nms_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_aware_box_nms_unit_tb: testbench for class-aware box suppression
// Drives directed and random box sets with random stalls on both streams,
// sweeps the IoU threshold and lets the checker judge every kept box.
// ----------------------------------------------------------------------------
module class_aware_box_nms_unit_tb;

  localparam int unsigned MAX_BOXES = cabn_pkg::MAX_BOXES_DEF;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [cabn_pkg::SCORE_W-1:0] cfg_wdata_i = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [cabn_pkg::DATA_W-1:0]  s_axis_tdata = '0;
  logic                         s_axis_tlast = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [cabn_pkg::DATA_W-1:0]  m_axis_tdata;
  logic                         m_axis_tlast;
  logic [0:0]                   m_axis_tuser;
  int                           fail_count, pending_count, kept_total, set_total;
  int                           hold_cycles = 0;
  int                           box_total = 0;
  cabn_pkg::entry_t             prev_box;

  always #6 clk_i = ~clk_i;

  class_aware_box_nms_unit #(.MAX_BOXES(MAX_BOXES)) uut (.*);
  class_aware_box_nms_unit_chk #(.MAX_BOXES(MAX_BOXES)) chk (.*);

  // Receiver: random stalls, with a long hold-off when requested.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 4) == 0) gap = 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Send one box; idle cycles first, then hold until accepted.
  task automatic send_box(cabn_pkg::entry_t e, logic last, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= cabn_pkg::DATA_W'(e);
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    box_total++;
    prev_box = e;
  endtask

  function automatic int rand_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  // Random box; often a well-formed box, at times reusing the previous score for ties.
  function automatic cabn_pkg::entry_t rand_box(int ncls);
    cabn_pkg::entry_t e;
    logic [95:0]      raw;
    int unsigned      x, y;
    raw = {$urandom, $urandom, $urandom};
    e = raw[cabn_pkg::ENTRY_W-1:0];
    case ($urandom_range(0, 5))
      0: ;
      1: e.score = prev_box.score;
      default: begin
        x = $urandom_range(0, 4000);
        y = $urandom_range(0, 4000);
        e.box.left   = 16'(x);
        e.box.top    = 16'(y);
        e.box.right  = 16'(x + $urandom_range(0, 600));
        e.box.bottom = 16'(y + $urandom_range(0, 600));
        if ($urandom_range(0, 20) == 0) e.box.right = 16'(x - $urandom_range(0, 50));
        e.cls = 7'($urandom_range(0, ncls - 1));
        if ($urandom_range(0, 30) == 0) e.cls = 7'd127;
      end
    endcase
    return e;
  endfunction

  // Stop offering and wait until every expected kept box has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [cabn_pkg::SCORE_W-1:0] thr);
    wait_drained();
    cfg_wdata_i <= thr;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_random_set(int n, int ncls, bit fast);
    for (int i = 0; i < n; i++)
      send_box(rand_box(ncls), i == n - 1, fast ? 0 : rand_gap());
  endtask

  initial begin
    cabn_pkg::entry_t e;
    int n;
    prev_box = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corner extremes, identical boxes, ties, inverted corners.
    e = '{cls: '1, score: '1, box: '{bottom: '1, right: '1, top: '0, left: '0}};
    send_box(e, 1'b0, 0);
    send_box(e, 1'b0, 0);                       // identical, suppressed
    e.cls = '0;
    send_box(e, 1'b0, 1);                       // other class, kept
    e = '{cls: 7'h55, score: 16'h0, box: '{bottom: '0, right: '0, top: '1, left: '1}};
    send_box(e, 1'b0, 0);                       // inverted corners
    send_box(e, 1'b0, 0);                       // inverted pair, zero overlap
    e = '{cls: 7'h2a, score: 16'h8000,
          box: '{bottom: 16'd100, right: 16'd100, top: 16'd0, left: 16'd0}};
    send_box(e, 1'b0, 0);
    e.box.right = 16'd90;
    send_box(e, 1'b0, 0);                       // equal score, high IoU
    e.box = '{bottom: 16'd100, right: 16'd200, top: 16'd0, left: 16'd100};
    send_box(e, 1'b1, 0);                       // touching edge, no overlap
    send_box(e, 1'b1, 2);                       // one-box set
    // Overflow: a full set plus dropped boxes, last box dropped too.
    write_threshold(16'd0);
    for (int i = 0; i < MAX_BOXES + 3; i++)
      send_box(rand_box(4), i == MAX_BOXES + 2, 0);
    write_threshold(16'hffff);
    send_random_set(6, 1, 0);
    write_threshold(16'd32768);
    send_random_set(6, 2, 0);

    // Long receiver stall while the sender keeps offering.
    wait_drained();
    hold_cycles = 400;
    send_random_set(12, 2, 1);
    send_random_set(5, 2, 1);

    // Random sets over several thresholds; the sender pauses between phases.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_threshold(cabn_pkg::THR_RESET);
        1: write_threshold(16'd1);
        2: write_threshold(16'hffff);
        default: write_threshold(16'($urandom));
      endcase
      while (box_total < 100 + ph * 72) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, MAX_BOXES) : $urandom_range(1, 8);
        send_random_set(n, $urandom_range(1, 4), $urandom_range(0, 4) == 0);
      end
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d boxes in %0d sets, checked %0d kept boxes.",
             box_total, set_total, kept_total);
    if (fail_count == 0 && pending_count == 0)
      $display("class_aware_box_nms_unit_tb OK");
    else
      $display("class_aware_box_nms_unit_tb NOT OK");
    $finish;
  end

  // Run limit.
  initial begin
    #50ms;
    $display("Run limit reached.");
    $display("class_aware_box_nms_unit_tb NOT OK");
    $finish;
  end
endmodule

// ===== class_aware_box_nms_unit.f =====
sv/cabn_pkg.sv
sv/cabn_iou_unit.sv
sv/class_aware_box_nms_unit.sv
sim/class_aware_box_nms_unit_chk.sv
sim/class_aware_box_nms_unit_tb.sv
